FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define IEFD_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("iefd assertion failed");

`define IEFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iefd assertion failed");

`else

`define IEFD_ASSERT(label, clk, rst, cond)

`define IEFD_ASSERT_IMPL(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/iefd_pkg.sv
// ----------------------------------------------------------------------------
// iefd_pkg
// Shared types and constants of the input event queue device.
// ----------------------------------------------------------------------------
package iefd_pkg;

   localparam logic [1:0] CMD_PUSH    = 2'd0;
   localparam logic [1:0] CMD_POINTER = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;
   localparam logic [1:0] CMD_WRITE   = 2'd3;

   localparam logic [1:0] PTR_WHEEL = 2'd1;

   localparam logic [11:0] OFF_DATA  = 12'h000;
   localparam logic [11:0] OFF_LEN   = 12'h004;
   localparam logic [11:0] OFF_BYTES = 12'h008;

   localparam logic [31:0] PG_NAME     = 32'h0000_0000;
   localparam logic [31:0] PG_CAPS     = 32'h0001_0000;
   localparam logic [31:0] PG_CAPS_REL = 32'h0001_0002;
   localparam logic [31:0] PG_ABS      = 32'h0002_0003;

   localparam logic [3:0] NAME_LEN     = 4'd9;
   localparam logic [3:0] CAPS_LEN     = 4'd1;
   localparam logic [3:0] CAPS_REL_LEN = 4'd2;
   localparam logic [3:0] CAPS_IDX     = 4'd9;
   localparam logic [3:0] REL_BASE     = 4'd10;

   localparam logic [15:0] WHEEL_TYPE = 16'd2;
   localparam logic [15:0] WHEEL_CODE = 16'd8;

   localparam logic [7:0] PAGE_ROM [16] = '{
      8'h70, 8'h61, 8'h6a, 8'h39, 8'h31, 8'h32, 8'h34, 8'h75, 8'h31,
      8'h06,
      8'h00, 8'h01,
      8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_PUSH  = 3'd1,
      OP_WHEEL = 3'd2,
      OP_POP   = 3'd3,
      OP_LEN   = 3'd4,
      OP_PAGE  = 3'd5,
      OP_SEL   = 3'd6,
      OP_ERR   = 3'd7
   } op_kind_type;

   typedef enum logic [1:0] {
      PH_INIT = 2'd0,
      PH_BUF  = 2'd1,
      PH_LIVE = 2'd2
   } phase_type;

   typedef struct packed {
      op_kind_type kind;
      logic [15:0] ev_type;
      logic [15:0] ev_code;
      logic [31:0] data;
      logic [11:0] page_off;
   } op_type;

endpackage

FILE: hw/rtl/iefd_ram.sv
// ----------------------------------------------------------------------------
// iefd_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module iefd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/iefd_front.sv
// ----------------------------------------------------------------------------
// iefd_front
// Accepts request words, decodes them into operations, two-entry queue.
// ----------------------------------------------------------------------------
module iefd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic [15:0]         req_event_type,
   input  logic [15:0]         req_event_code,
   input  logic signed [31:0]  req_event_value,
   input  logic [1:0]          req_pointer_kind,
   input  logic [11:0]         req_bus_offset,
   input  logic [31:0]         req_write_data,
   output logic                q_valid,
   output iefd_pkg::op_type    q_op,
   input  logic                q_take
);

   iefd_pkg::op_type op_new;
   iefd_pkg::op_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   always_comb begin
      op_new          = '0;
      op_new.ev_type  = req_event_type;
      op_new.ev_code  = req_event_code;
      op_new.data     = (req_command == iefd_pkg::CMD_WRITE) ? req_write_data
                                                             : $unsigned(req_event_value);
      op_new.page_off = req_bus_offset - iefd_pkg::OFF_BYTES;
      unique case (req_command)
         iefd_pkg::CMD_PUSH: begin
            op_new.kind = iefd_pkg::OP_PUSH;
         end
         iefd_pkg::CMD_POINTER: begin
            op_new.kind = (req_pointer_kind == iefd_pkg::PTR_WHEEL) ? iefd_pkg::OP_WHEEL
                                                                    : iefd_pkg::OP_NOP;
         end
         iefd_pkg::CMD_READ: begin
            if (req_bus_offset == iefd_pkg::OFF_DATA) begin
               op_new.kind = iefd_pkg::OP_POP;
            end else if (req_bus_offset == iefd_pkg::OFF_LEN) begin
               op_new.kind = iefd_pkg::OP_LEN;
            end else if (req_bus_offset >= iefd_pkg::OFF_BYTES) begin
               op_new.kind = iefd_pkg::OP_PAGE;
            end else begin
               op_new.kind = iefd_pkg::OP_ERR;
            end
         end
         iefd_pkg::CMD_WRITE: begin
            op_new.kind = (req_bus_offset == iefd_pkg::OFF_DATA) ? iefd_pkg::OP_SEL
                                                                 : iefd_pkg::OP_ERR;
         end
         default: begin
            op_new.kind = iefd_pkg::OP_NOP;
         end
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_op      = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_take && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

FILE: hw/rtl/iefd_back.sv
// ----------------------------------------------------------------------------
// iefd_back
// Executes queued operations: event ring, page registers, interrupt, result.
// ----------------------------------------------------------------------------
module iefd_back #(
   parameter int RING_WORDS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  iefd_pkg::op_type  q_op,
   output logic              q_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_read_data,
   output logic              rsp_irq_level,
   output logic              rsp_access_error,
   output logic [1:0]        rsp_dropped_triplets
);

   localparam int AW = $clog2(RING_WORDS);
   localparam logic [AW-1:0] LAST_IDX = AW'(RING_WORDS - 1);
   localparam logic [AW:0]   DEPTH_W  = (AW+1)'(RING_WORDS);
   localparam logic [AW+1:0] DEPTH_X  = (AW+2)'(RING_WORDS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PUSH = 3'b010,
      ST_POP  = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   iefd_pkg::op_type    op_ff, op_in;
   logic [AW-1:0]       ri_ff, ri_in, wi_ff, wi_in;
   iefd_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         page_ff, page_in;
   logic                irq_ff, irq_in;
   logic                trip_ff, trip_in;
   logic [1:0]          wcnt_ff, wcnt_in;
   logic [1:0]          lost_ff, lost_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_irq_ff, rsp_irq_in;
   logic                rsp_err_ff, rsp_err_in;
   logic [1:0]          rsp_lost_ff, rsp_lost_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_wdata, ram_rdata;

   logic [AW:0]   used;
   logic          fits, ring_empty, rsp_free;
   logic [AW-1:0] ri_next, wi_next;
   logic [3:0]    sel_len;
   logic [7:0]    page_byte;
   logic          page_hit;
   logic          finish, trip_end;
   logic [31:0]   fin_data;
   logic          fin_err;
   logic [1:0]    fin_lost, lost_next;
   logic          wheel;

   iefd_ram #(
      .WIDTH (32),
      .DEPTH (RING_WORDS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (wi_ff >= ri_ff) begin
         used = {1'b0, wi_ff} - {1'b0, ri_ff};
      end else begin
         used = ({1'b0, wi_ff} + DEPTH_W) - {1'b0, ri_ff};
      end
      fits       = ((AW+2)'(used) + (AW+2)'(3)) < DEPTH_X;
      ring_empty = (ri_ff == wi_ff);
      ri_next    = (ri_ff == LAST_IDX) ? '0 : ri_ff + 1'b1;
      wi_next    = (wi_ff == LAST_IDX) ? '0 : wi_ff + 1'b1;
      rsp_free   = !rsp_valid_ff || rsp_ready;
      wheel      = (op_ff.kind == iefd_pkg::OP_WHEEL);
   end

   // page length and byte of the selected page
   always_comb begin
      page_byte = 8'd0;
      if (page_ff == iefd_pkg::PG_NAME) begin
         sel_len   = iefd_pkg::NAME_LEN;
         page_byte = iefd_pkg::PAGE_ROM[q_op.page_off[3:0]];
      end else if (page_ff == iefd_pkg::PG_CAPS) begin
         sel_len   = iefd_pkg::CAPS_LEN;
         page_byte = iefd_pkg::PAGE_ROM[iefd_pkg::CAPS_IDX];
      end else if (page_ff == iefd_pkg::PG_CAPS_REL) begin
         sel_len   = iefd_pkg::CAPS_REL_LEN;
         page_byte = iefd_pkg::PAGE_ROM[iefd_pkg::REL_BASE + q_op.page_off[3:0]];
      end else begin
         sel_len   = 4'd0;
      end
      page_hit = q_op.page_off < {8'd0, sel_len};
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      ri_in     = ri_ff;
      wi_in     = wi_ff;
      phase_in  = phase_ff;
      page_in   = page_ff;
      irq_in    = irq_ff;
      trip_in   = trip_ff;
      wcnt_in   = wcnt_ff;
      lost_in   = lost_ff;
      q_take    = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_addr  = ri_ff;
      ram_wdata = '0;
      finish    = 1'b0;
      fin_data  = '0;
      fin_err   = 1'b0;
      fin_lost  = 2'd0;
      trip_end  = 1'b0;
      lost_next = lost_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && rsp_free) begin
               q_take = 1'b1;
               op_in  = q_op;
               case (q_op.kind) inside
                  iefd_pkg::OP_PUSH, iefd_pkg::OP_WHEEL: begin
                     state_in = ST_PUSH;
                     trip_in  = 1'b0;
                     wcnt_in  = 2'd0;
                     lost_in  = 2'd0;
                  end
                  iefd_pkg::OP_POP: begin
                     if (ring_empty) begin
                        finish = 1'b1;
                     end else begin
                        ram_re   = 1'b1;
                        ri_in    = ri_next;
                        state_in = ST_POP;
                        if (ri_next == wi_ff) begin
                           irq_in = 1'b0;
                        end
                     end
                  end
                  iefd_pkg::OP_LEN: begin
                     fin_data = {28'd0, sel_len};
                     finish   = 1'b1;
                     if (page_ff == iefd_pkg::PG_ABS) begin
                        if (phase_ff == iefd_pkg::PH_BUF) begin
                           irq_in = 1'b1;
                        end
                        phase_in = iefd_pkg::PH_LIVE;
                     end
                  end
                  iefd_pkg::OP_PAGE: begin
                     fin_data = page_hit ? {24'd0, page_byte} : 32'd0;
                     finish   = 1'b1;
                  end
                  iefd_pkg::OP_SEL: begin
                     page_in = q_op.data;
                     finish  = 1'b1;
                  end
                  iefd_pkg::OP_ERR: begin
                     fin_err = 1'b1;
                     finish  = 1'b1;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            fin_data = ram_rdata;
            finish   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_PUSH: begin
            ram_addr = wi_ff;
            case (wcnt_ff)
               2'd0: ram_wdata = {16'd0, wheel ? (trip_ff ? 16'd0 : iefd_pkg::WHEEL_TYPE)
                                                : op_ff.ev_type};
               2'd1: ram_wdata = {16'd0, wheel ? (trip_ff ? 16'd0 : iefd_pkg::WHEEL_CODE)
                                                : op_ff.ev_code};
               default: ram_wdata = trip_ff ? 32'd0 : op_ff.data;
            endcase
            if (wcnt_ff == 2'd0) begin
               if (fits) begin
                  ram_we  = 1'b1;
                  wi_in   = wi_next;
                  wcnt_in = 2'd1;
                  if (ring_empty) begin
                     if (phase_ff == iefd_pkg::PH_LIVE) begin
                        irq_in = 1'b1;
                     end else begin
                        phase_in = iefd_pkg::PH_BUF;
                     end
                  end
               end else begin
                  lost_next = lost_ff + 2'd1;
                  trip_end  = 1'b1;
               end
            end else begin
               ram_we = 1'b1;
               wi_in  = wi_next;
               if (wcnt_ff == 2'd2) begin
                  trip_end = 1'b1;
               end else begin
                  wcnt_in = wcnt_ff + 2'd1;
               end
            end
            lost_in = lost_next;
            if (trip_end) begin
               if (wheel && !trip_ff) begin
                  trip_in = 1'b1;
                  wcnt_in = 2'd0;
               end else begin
                  finish   = 1'b1;
                  fin_lost = lost_next;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_data_in = finish ? fin_data : rsp_data_ff;
      rsp_irq_in  = finish ? irq_in   : rsp_irq_ff;
      rsp_err_in  = finish ? fin_err  : rsp_err_ff;
      rsp_lost_in = finish ? fin_lost : rsp_lost_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ri_ff        <= '0;
         wi_ff        <= '0;
         phase_ff     <= iefd_pkg::PH_INIT;
         page_ff      <= iefd_pkg::PG_NAME;
         irq_ff       <= 1'b0;
         trip_ff      <= 1'b0;
         wcnt_ff      <= 2'd0;
         lost_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ri_ff        <= ri_in;
         wi_ff        <= wi_in;
         phase_ff     <= phase_in;
         page_ff      <= page_in;
         irq_ff       <= irq_in;
         trip_ff      <= trip_in;
         wcnt_ff      <= wcnt_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_lost_ff <= rsp_lost_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_data        = rsp_data_ff;
   assign rsp_irq_level        = rsp_irq_ff;
   assign rsp_access_error     = rsp_err_ff;
   assign rsp_dropped_triplets = rsp_lost_ff;

endmodule

FILE: hw/rtl/input_event_fifo_device_top.sv
// ----------------------------------------------------------------------------
// input_event_fifo_device_top
// Flow: a request word is queued at acceptance; the back end registers the
// result of a page/length/write/error word on taking it, of a ring pop after
// the RAM read, of a push or wheel after its triplets (dropped: no writes).
// Throughput: one simple word per cycle unless stalled; ring port bounds pushes.
// Reset: synchronous; clears ring indices, phase, page select, interrupt.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module input_event_fifo_device_top #(
   parameter int RING_WORDS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic [15:0]         req_event_type,
   input  logic [15:0]         req_event_code,
   input  logic signed [31:0]  req_event_value,
   input  logic [1:0]          req_pointer_kind,
   input  logic [11:0]         req_bus_offset,
   input  logic [31:0]         req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_read_data,
   output logic                rsp_irq_level,
   output logic                rsp_access_error,
   output logic [1:0]          rsp_dropped_triplets
);

   logic             q_valid;
   logic             q_take;
   iefd_pkg::op_type q_op;

   iefd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_event_type   (req_event_type),
      .req_event_code   (req_event_code),
      .req_event_value  (req_event_value),
      .req_pointer_kind (req_pointer_kind),
      .req_bus_offset   (req_bus_offset),
      .req_write_data   (req_write_data),
      .q_valid          (q_valid),
      .q_op             (q_op),
      .q_take           (q_take)
   );

   iefd_back #(
      .RING_WORDS (RING_WORDS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_op                 (q_op),
      .q_take               (q_take),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_data        (rsp_read_data),
      .rsp_irq_level        (rsp_irq_level),
      .rsp_access_error     (rsp_access_error),
      .rsp_dropped_triplets (rsp_dropped_triplets)
   );

   `IEFD_ASSERT_IMPL(a_take_needs_word, clock, reset, q_take, q_valid)
   `IEFD_ASSERT_IMPL(a_stall_means_backlog, clock, reset, !req_ready, q_valid)
   `IEFD_ASSERT(a_lost_range, clock, reset, !rsp_valid || (rsp_dropped_triplets != 2'd3))

endmodule

FILE: test/event_device_checker.sv
// ----------------------------------------------------------------------------
// event_device_checker
// Watches the request and response channels of the input event queue device,
// predicts each response from its own model of the event ring, the driver
// phase, the page select and the interrupt line, and compares field by field.
// ----------------------------------------------------------------------------
module event_device_checker #(
   parameter int RING_WORDS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [15:0]        req_event_type,
   input  logic [15:0]        req_event_code,
   input  logic signed [31:0] req_event_value,
   input  logic [1:0]         req_pointer_kind,
   input  logic [11:0]        req_bus_offset,
   input  logic [31:0]        req_write_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [31:0]        rsp_read_data,
   input  logic               rsp_irq_level,
   input  logic               rsp_access_error,
   input  logic [1:0]         rsp_dropped_triplets,
   output int                 mismatches,
   output int                 outstanding,
   output int                 ring_level
);
   timeunit 1ns;
   timeprecision 1ps;
   import iefd_pkg::*;

   localparam logic [7:0] NAME_BYTES [9] = '{
      8'h70, 8'h61, 8'h6a, 8'h39, 8'h31, 8'h32, 8'h34, 8'h75, 8'h31
   };
   localparam logic [7:0] TYPE_BITS = 8'h06;
   localparam logic [7:0] REL_BITS [2] = '{8'h00, 8'h01};

   typedef struct {
      logic [31:0] read_data;
      logic        irq_level;
      logic        access_error;
      logic [1:0]  dropped;
   } answer_type;

   logic [31:0] ring_words [$];
   answer_type  expected_answers [$];
   phase_type   phase;
   logic [31:0] page_sel;
   logic        irq_line;
   int          errors;

   initial begin
      mismatches = 0;
      outstanding = 0;
      ring_level = 0;
      errors = 0;
      phase = PH_INIT;
      page_sel = PG_NAME;
      irq_line = 1'b0;
   end

   // returns 1 when the triplet does not fit
   function automatic logic ring_add_triplet(input logic [31:0] t, input logic [31:0] c,
         input logic [31:0] v);
      if (ring_words.size() + 3 >= RING_WORDS) return 1'b1;
      if (ring_words.size() == 0) begin
         if (phase == PH_LIVE) irq_line = 1'b1;
         else phase = PH_BUF;
      end
      ring_words.push_back(t);
      ring_words.push_back(c);
      ring_words.push_back(v);
      return 1'b0;
   endfunction

   function automatic logic [31:0] pop_event_word();
      logic [31:0] w;
      if (ring_words.size() == 0) return '0;
      w = ring_words.pop_front();
      if (ring_words.size() == 0) irq_line = 1'b0;
      return w;
   endfunction

   function automatic logic [31:0] page_length();
      case (page_sel)
         PG_NAME:     return 32'd9;
         PG_CAPS:     return 32'd1;
         PG_CAPS_REL: return 32'd2;
         default:     return 32'd0;
      endcase
   endfunction

   function automatic logic [31:0] page_byte(input int index);
      if (index >= int'(page_length())) return '0;
      case (page_sel)
         PG_NAME:     return {24'd0, NAME_BYTES[index]};
         PG_CAPS:     return {24'd0, TYPE_BITS};
         PG_CAPS_REL: return {24'd0, REL_BITS[index]};
         default:     return '0;
      endcase
   endfunction

   function automatic answer_type device_answer(input logic [1:0] cmd,
         input logic [15:0] etype, input logic [15:0] ecode, input logic [31:0] evalue,
         input logic [1:0] pkind, input logic [11:0] off, input logic [31:0] wdata);
      answer_type a;
      a.read_data = '0;
      a.access_error = 1'b0;
      a.dropped = '0;
      case (cmd)
         CMD_PUSH: begin
            a.dropped = {1'b0, ring_add_triplet({16'd0, etype}, {16'd0, ecode}, evalue)};
         end
         CMD_POINTER: begin
            if (pkind == PTR_WHEEL) begin
               a.dropped = {1'b0, ring_add_triplet({16'd0, WHEEL_TYPE}, {16'd0, WHEEL_CODE},
                                                   evalue)};
               a.dropped = a.dropped + {1'b0, ring_add_triplet('0, '0, '0)};
            end
         end
         CMD_READ: begin
            if (off == OFF_LEN && page_sel == PG_ABS) begin
               if (phase == PH_BUF) irq_line = 1'b1;
               phase = PH_LIVE;
            end
            if (off == OFF_DATA) a.read_data = pop_event_word();
            else if (off == OFF_LEN) a.read_data = page_length();
            else if (off >= OFF_BYTES) a.read_data = page_byte(int'(off - OFF_BYTES));
            else a.access_error = 1'b1;
         end
         default: begin
            if (off == OFF_DATA) page_sel = wdata;
            else a.access_error = 1'b1;
         end
      endcase
      a.irq_level = irq_line;
      return a;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         ring_words.delete();
         expected_answers.delete();
         phase = PH_INIT;
         page_sel = PG_NAME;
         irq_line = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_answers.push_back(device_answer(req_command, req_event_type,
               req_event_code, req_event_value, req_pointer_kind, req_bus_offset,
               req_write_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t ns unexpected word: expected none, actual data %0h irq %0b",
                        $time, rsp_read_data, rsp_irq_level);
               errors++;
            end else begin
               want = expected_answers.pop_front();
               compare_field("read_data", want.read_data, rsp_read_data);
               compare_field("irq_level", 32'(want.irq_level), 32'(rsp_irq_level));
               compare_field("access_error", 32'(want.access_error), 32'(rsp_access_error));
               compare_field("dropped_triplets", 32'(want.dropped), 32'(rsp_dropped_triplets));
            end
         end
      end
      mismatches <= errors;
      outstanding <= expected_answers.size();
      ring_level <= ring_words.size();
   end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the input event queue device with a directed opening and then
// random pushes, wheel reports and bus accesses, filling and draining the
// ring under varying sender gaps and receiver stalls; a checker beside the
// device predicts and compares every response word.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import iefd_pkg::*;

   localparam int RING_WORDS = 1024;
   localparam int QUIET_LIMIT = 2000;
   localparam int WORDS_PER_PHASE = 500;
   localparam int IDLE_PLAN [4] = '{0, 83, 0, 38};
   localparam int STALL_PLAN [4] = '{0, 0, 83, 38};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_command = CMD_READ;
   logic [15:0]        req_event_type = '0;
   logic [15:0]        req_event_code = '0;
   logic signed [31:0] req_event_value = '0;
   logic [1:0]         req_pointer_kind = '0;
   logic [11:0]        req_bus_offset = '0;
   logic [31:0]        req_write_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_read_data;
   logic               rsp_irq_level;
   logic               rsp_access_error;
   logic [1:0]         rsp_dropped_triplets;
   int                 mismatches;
   int                 outstanding;
   int                 ring_level;
   int                 idle_pct = 0;
   int                 stall_pct = 0;

   input_event_fifo_device_top #(.RING_WORDS(RING_WORDS)) DUT (.*);

   event_device_checker #(.RING_WORDS(RING_WORDS)) checker_i (.*);

   always #6 clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   task automatic send_word(input logic [1:0] cmd, input logic [15:0] etype,
         input logic [15:0] ecode, input logic [31:0] evalue, input logic [1:0] pkind,
         input logic [11:0] off, input logic [31:0] wdata);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_event_type <= etype;
      req_event_code <= ecode;
      req_event_value <= evalue;
      req_pointer_kind <= pkind;
      req_bus_offset <= off;
      req_write_data <= wdata;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic push_event(input logic [15:0] etype, input logic [15:0] ecode,
         input logic [31:0] evalue);
      send_word(CMD_PUSH, etype, ecode, evalue, 2'($urandom), 12'($urandom), $urandom);
   endtask

   task automatic pointer_report(input logic [1:0] kind, input logic [31:0] dy);
      send_word(CMD_POINTER, 16'($urandom), 16'($urandom), dy, kind, 12'($urandom),
                $urandom);
   endtask

   task automatic bus_read(input logic [11:0] off);
      send_word(CMD_READ, 16'($urandom), 16'($urandom), $urandom, 2'($urandom), off,
                $urandom);
   endtask

   task automatic bus_write(input logic [11:0] off, input logic [31:0] data);
      send_word(CMD_WRITE, 16'($urandom), 16'($urandom), $urandom, 2'($urandom), off,
                data);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_page();
      case ($urandom_range(5))
         0: return PG_NAME;
         1: return PG_CAPS;
         2: return PG_CAPS_REL;
         3: return PG_ABS;
         4: return PG_CAPS + $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] other_kind();
      logic [1:0] k;
      k = 2'($urandom_range(2));
      if (k >= PTR_WHEEL) k = k + 2'd1;
      return k;
   endfunction

   task automatic misc_bus();
      case ($urandom_range(5))
         0: bus_read(OFF_LEN);
         1: bus_read(OFF_BYTES + 12'($urandom_range(15)));
         2: bus_read(12'($urandom));
         3: bus_read(12'($urandom_range(7)));
         4: bus_write(OFF_DATA, pick_page());
         default: bus_write(12'($urandom), $urandom);
      endcase
   endtask

   task automatic random_word(input bit filling);
      int pick;
      pick = $urandom_range(99);
      if (filling) begin
         if (pick < 45) push_event(16'($urandom), 16'($urandom), $urandom);
         else if (pick < 82) pointer_report(PTR_WHEEL, $urandom);
         else if (pick < 85) pointer_report(other_kind(), $urandom);
         else if (pick < 90) bus_read(OFF_DATA);
         else misc_bus();
      end else begin
         if (pick < 85) bus_read(OFF_DATA);
         else if (pick < 88) push_event(16'($urandom), 16'($urandom), $urandom);
         else if (pick < 90) pointer_report(PTR_WHEEL, $urandom);
         else misc_bus();
      end
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("input_event_fifo_device_top test failed");
      $finish;
   end

   initial begin : stimulus
      bit filling;
      int fill_goal;
      int overfill_left;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // name page, reads at edges of each offset range, empty ring
      bus_read(OFF_LEN);
      bus_read(OFF_BYTES);
      bus_read(12'd16);
      bus_read(12'd17);
      bus_read(12'hfff);
      bus_read(12'd1);
      bus_read(12'd7);
      bus_read(OFF_DATA);
      bus_write(12'd5, 32'hffff_ffff);
      // first push before the driver is live: buffered, no interrupt
      push_event(16'hffff, 16'hffff, 32'h8000_0000);
      bus_write(OFF_DATA, PG_CAPS);
      bus_read(OFF_LEN);
      bus_read(OFF_BYTES);
      bus_read(12'd9);
      bus_write(OFF_DATA, PG_CAPS_REL);
      bus_read(12'd9);
      // absolute-axis length read turns the driver live and raises the pending irq
      bus_write(OFF_DATA, PG_ABS);
      bus_read(OFF_LEN);
      bus_read(OFF_DATA);
      bus_read(OFF_DATA);
      bus_read(OFF_DATA);
      pointer_report(2'd2, 32'h7fff_ffff);
      pointer_report(PTR_WHEEL, 32'h7fff_ffff);
      push_event(16'h0000, 16'h0000, 32'h7fff_ffff);
      bus_write(OFF_DATA, PG_NAME);

      // first fill runs the ring to full, later ones stay shallow
      filling = 1'b1;
      fill_goal = RING_WORDS;
      overfill_left = 40;
      for (int ph = 0; ph < 4; ph++) begin
         wait_drained();
         idle_pct = IDLE_PLAN[ph];
         stall_pct = STALL_PLAN[ph];
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (filling) begin
               if (ring_level + 6 >= fill_goal) begin
                  if (overfill_left == 0) filling = 1'b0;
                  else overfill_left--;
               end
            end else if (ring_level == 0 && $urandom_range(3) == 0) begin
               filling = 1'b1;
               fill_goal = $urandom_range(3, 90);
               overfill_left = 0;
            end
            if ($urandom_range(199) == 0) wait_drained();
            random_word(filling);
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("input_event_fifo_device_top test passed");
      end else begin
         $display("input_event_fifo_device_top test failed");
      end
      $finish;
   end

endmodule

FILE: input_event_fifo_device_top.f
+incdir+hw/rtl
hw/rtl/iefd_pkg.sv
hw/rtl/iefd_ram.sv
hw/rtl/iefd_front.sv
hw/rtl/iefd_back.sv
hw/rtl/input_event_fifo_device_top.sv
test/event_device_checker.sv
test/testbench.sv
